### hdl/fbcm_pkg.sv
// Package for the FAT block chain manager.
// Holds widths, codes, the link entry format, datapath ops and controller states.
// Depends on nothing.
package fbcm_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = BLK_W + 1;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    REQ_FORMAT, REQ_LOOKUP, REQ_MAP_EXTEND, REQ_FREE_CHAIN, REQ_TRUNCATE
  } req_t;

  typedef enum logic [1:0] {ST_OK, ST_END, ST_NO_SPACE} status_t;

  typedef enum logic [1:0] {TAG_BLK, TAG_EOF, TAG_FREE} tag_t;

  typedef struct packed {
    tag_t tag;
    blk_t num;
  } link_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_LK_START, OP_RD_CUR, OP_LK_STEP, OP_HIT,
    OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_NEXT, OP_SET_HEAD, OP_NOSPACE,
    OP_ME_START, OP_ME_CLAIM_CUR, OP_ME_FOLLOW, OP_ME_CLAIM_NXT, OP_LINK,
    OP_LINK2, OP_FC_START, OP_FREE_STEP, OP_TR_START, OP_TR_STEP, OP_TR_CUT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    req_t req;
    logic has_head;
    logic cnt_done;
    logic clr_last;
    logic scan_last;
    logic cur_valid;
    logic out_free;
    tag_t rd_tag;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISPATCH, S_LK_CHK, S_LK_WAIT, S_ME_START, S_ME_HWAIT,
    S_ME_CHK, S_ME_WAIT, S_ME_NXW, S_SC_RD, S_SC_WAIT, S_ME_LINK2, S_FC_RD,
    S_FC_WAIT, S_TR_CHK, S_TR_WAIT, S_TR_CUT, S_DONE
  } state_t;

endpackage

### hdl/fbcm_req_if.sv
// Request channel of the FAT block chain manager.
// Depends on fbcm_pkg for field widths.
interface fbcm_req_if;
  import fbcm_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] req_type;
  logic head_valid;
  blk_t head_block;
  cnt_t block_count;
  modport source(output valid, req_type, head_valid, head_block, block_count,
                 input ready);
  modport sink(input valid, req_type, head_valid, head_block, block_count,
               output ready);
endinterface

### hdl/fbcm_rsp_if.sv
// Response channel of the FAT block chain manager.
// Depends on fbcm_pkg for field widths.
interface fbcm_rsp_if;
  import fbcm_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic block_valid;
  blk_t block_num;
  logic new_head_valid;
  blk_t new_head_block;
  cnt_t changed_count;
  modport source(output valid, status, block_valid, block_num, new_head_valid,
                 new_head_block, changed_count, input ready);
  modport sink(input valid, status, block_valid, block_num, new_head_valid,
               new_head_block, changed_count, output ready);
endinterface

### hdl/fat_block_chain_manager.sv
// Top level of the FAT block chain manager: controller plus datapath.
// Depends on fbcm_pkg, fbcm_req_if, fbcm_rsp_if, fbcm_ctrl and fbcm_dp.
//
// The block keeps a 4096-entry table of next-block links and serves one
// request word at a time, giving one response word for each. After reset,
// and for a format request, a clearing pass writes one entry per cycle, so
// requests are refused until all 4096 entries are cleared. A lookup walks
// the chain one link at a time, map-extend walks links and scans the table
// for a free block when needed, and free or truncate visits each block, all
// paced by the single read port of the link table and its registered read
// data. The free scan starts at the lowest entry that may be free, so
// repeated allocations do not rescan the used blocks below it.
module fat_block_chain_manager (
  input logic        clk,
  input logic        rst,
  fbcm_req_if.sink   req,
  fbcm_rsp_if.source rsp
);
  import fbcm_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  fbcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .op       (op)
  );

  fbcm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .req_type    (req.req_type),
    .head_valid  (req.head_valid),
    .head_block  (req.head_block),
    .block_count (req.block_count),
    .rsp         (rsp)
  );

endmodule

### hdl/fbcm_dp.sv
// Datapath of the FAT block chain manager: link table memory, walk registers
// and the response register. Executes one op per cycle. Depends on fbcm_pkg.
module fbcm_dp (
  input  logic            clk,
  input  logic            rst,
  input  fbcm_pkg::dp_op_t op,
  output fbcm_pkg::dp_stat_t stat,
  input  logic [2:0]      req_type,
  input  logic            head_valid,
  input  fbcm_pkg::blk_t  head_block,
  input  fbcm_pkg::cnt_t  block_count,
  fbcm_rsp_if.source      rsp
);
  import fbcm_pkg::*;

  link_t mem [NUM_BLOCKS];
  link_t rd;
  logic  we;
  blk_t  waddr, raddr;
  link_t wdata;

  req_t    req_q;
  logic    has_head, cur_valid, prv_valid;
  blk_t    head, cur, prv, nxt, hint, scan, clr;
  cnt_t    n, cnt, changed;
  status_t status;
  logic    bval, nhv;
  blk_t    bnum, nhead;

  logic    out_valid;
  status_t out_status;
  logic    out_bval, out_nhv;
  blk_t    out_bnum, out_nhead;
  cnt_t    out_changed;

  always_comb begin
    raddr = cur;
    we = 1'b0;
    waddr = cur;
    wdata = '{tag: TAG_EOF, num: '0};
    unique case (op)
      OP_CLR: begin
        we = 1'b1;
        waddr = clr;
        wdata = '{tag: TAG_FREE, num: '0};
      end
      OP_SCAN_RD: raddr = scan;
      OP_ME_START: raddr = head;
      OP_ME_FOLLOW: raddr = rd.num;
      OP_SET_HEAD, OP_LINK2: begin
        we = 1'b1;
        waddr = scan;
      end
      OP_ME_CLAIM_CUR: we = (rd.tag == TAG_FREE);
      OP_ME_CLAIM_NXT: begin
        we = (rd.tag == TAG_FREE);
        waddr = nxt;
      end
      OP_LINK: begin
        we = 1'b1;
        wdata = '{tag: TAG_BLK, num: scan};
      end
      OP_FREE_STEP: begin
        we = (rd.tag != TAG_FREE);
        wdata = '{tag: TAG_FREE, num: '0};
      end
      OP_TR_CUT: begin
        we = prv_valid;
        waddr = prv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      hint <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && op != OP_EMIT) out_valid <= 1'b0;
      unique case (op)
        OP_CLR: begin
          clr <= clr + 1'b1;
          hint <= '0;
        end
        OP_LOAD: begin
          req_q <= req_t'(req_type);
          has_head <= head_valid;
          head <= head_block;
          n <= block_count;
          changed <= '0;
          status <= ST_OK;
          bval <= 1'b0;
          bnum <= '0;
          nhv <= 1'b0;
          nhead <= '0;
          clr <= '0;
        end
        OP_LK_START: begin
          nhv <= has_head;
          nhead <= has_head ? head : '0;
          cur <= head;
          cnt <= '0;
          if (!has_head) status <= ST_END;
        end
        OP_LK_STEP: begin
          if (rd.tag == TAG_BLK) begin
            cur <= rd.num;
            cnt <= cnt + 1'b1;
          end else begin
            status <= ST_END;
          end
        end
        OP_HIT: begin
          bval <= 1'b1;
          bnum <= cur;
        end
        OP_SCAN_INIT: scan <= hint;
        OP_SCAN_NEXT: scan <= scan + 1'b1;
        OP_SET_HEAD: begin
          head <= scan;
          hint <= scan;
          changed <= changed + 1'b1;
        end
        OP_NOSPACE: status <= ST_NO_SPACE;
        OP_ME_START: begin
          nhv <= 1'b1;
          nhead <= head;
          cur <= head;
          cnt <= '0;
        end
        OP_ME_CLAIM_CUR: if (rd.tag == TAG_FREE) changed <= changed + 1'b1;
        OP_ME_FOLLOW: nxt <= rd.num;
        OP_ME_CLAIM_NXT: begin
          if (rd.tag == TAG_FREE) changed <= changed + 1'b1;
          cur <= nxt;
          cnt <= cnt + 1'b1;
        end
        OP_LINK: hint <= scan;
        OP_LINK2: begin
          changed <= changed + 1'b1;
          cur <= scan;
          cnt <= cnt + 1'b1;
        end
        OP_FC_START: cur <= head;
        OP_FREE_STEP: begin
          if (rd.tag != TAG_FREE) begin
            changed <= changed + 1'b1;
            cur <= rd.num;
            if (cur < hint) hint <= cur;
          end
        end
        OP_TR_START: begin
          cur <= head;
          cur_valid <= has_head;
          prv_valid <= 1'b0;
          cnt <= '0;
        end
        OP_TR_STEP: begin
          prv <= cur;
          prv_valid <= 1'b1;
          cur <= rd.num;
          cur_valid <= (rd.tag == TAG_BLK);
          cnt <= cnt + 1'b1;
        end
        OP_TR_CUT: begin
          if (prv_valid) begin
            nhv <= 1'b1;
            nhead <= head;
            bval <= 1'b1;
            bnum <= prv;
          end
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
          out_status <= status;
          out_bval <= bval;
          out_bnum <= bnum;
          out_nhv <= nhv;
          out_nhead <= nhead;
          out_changed <= changed;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.req = req_q;
    stat.has_head = has_head;
    stat.cnt_done = (cnt == n);
    stat.clr_last = (clr == blk_t'(NUM_BLOCKS - 1));
    stat.scan_last = (scan == blk_t'(NUM_BLOCKS - 1));
    stat.cur_valid = cur_valid;
    stat.out_free = !out_valid || rsp.ready;
    stat.rd_tag = rd.tag;
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.block_valid = out_bval;
  assign rsp.block_num = out_bnum;
  assign rsp.new_head_valid = out_nhv;
  assign rsp.new_head_block = out_nhead;
  assign rsp.changed_count = out_changed;

endmodule

### hdl/fbcm_ctrl.sv
// Controller of the FAT block chain manager: sequences the clearing pass,
// chain walks and free scans as datapath ops. Depends on fbcm_pkg.
module fbcm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbcm_pkg::dp_stat_t stat,
  output fbcm_pkg::dp_op_t   op
);
  import fbcm_pkg::*;

  state_t state, state_next;
  logic   clr_reply, clr_reply_next;
  logic   find_head, find_head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_reply <= 1'b0;
      find_head <= 1'b0;
    end else begin
      state <= state_next;
      clr_reply <= clr_reply_next;
      find_head <= find_head_next;
    end
  end

  always_comb begin
    state_next = state;
    clr_reply_next = clr_reply;
    find_head_next = find_head;
    op = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_CLR: begin
        op = OP_CLR;
        if (stat.clr_last) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
          clr_reply_next = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.req)
          REQ_FORMAT: begin
            clr_reply_next = 1'b1;
            state_next = S_CLR;
          end
          REQ_LOOKUP: begin
            op = OP_LK_START;
            state_next = stat.has_head ? S_LK_CHK : S_DONE;
          end
          REQ_MAP_EXTEND: begin
            if (stat.has_head) begin
              state_next = S_ME_START;
            end else begin
              op = OP_SCAN_INIT;
              find_head_next = 1'b1;
              state_next = S_SC_RD;
            end
          end
          REQ_FREE_CHAIN: begin
            op = OP_FC_START;
            state_next = stat.has_head ? S_FC_RD : S_DONE;
          end
          REQ_TRUNCATE: begin
            op = OP_TR_START;
            state_next = S_TR_CHK;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_LK_CHK: begin
        if (stat.cnt_done) begin
          op = OP_HIT;
          state_next = S_DONE;
        end else begin
          op = OP_RD_CUR;
          state_next = S_LK_WAIT;
        end
      end
      S_LK_WAIT: begin
        op = OP_LK_STEP;
        state_next = (stat.rd_tag == TAG_BLK) ? S_LK_CHK : S_DONE;
      end
      S_ME_START: begin
        op = OP_ME_START;
        state_next = S_ME_HWAIT;
      end
      S_ME_HWAIT: begin
        op = OP_ME_CLAIM_CUR;
        state_next = S_ME_CHK;
      end
      S_ME_CHK: begin
        if (stat.cnt_done) begin
          op = OP_HIT;
          state_next = S_DONE;
        end else begin
          op = OP_RD_CUR;
          state_next = S_ME_WAIT;
        end
      end
      S_ME_WAIT: begin
        if (stat.rd_tag == TAG_BLK) begin
          op = OP_ME_FOLLOW;
          state_next = S_ME_NXW;
        end else begin
          op = OP_SCAN_INIT;
          find_head_next = 1'b0;
          state_next = S_SC_RD;
        end
      end
      S_ME_NXW: begin
        op = OP_ME_CLAIM_NXT;
        state_next = S_ME_CHK;
      end
      S_SC_RD: begin
        op = OP_SCAN_RD;
        state_next = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (stat.rd_tag == TAG_FREE) begin
          if (find_head) begin
            op = OP_SET_HEAD;
            state_next = S_ME_START;
          end else begin
            op = OP_LINK;
            state_next = S_ME_LINK2;
          end
        end else if (stat.scan_last) begin
          op = OP_NOSPACE;
          state_next = S_DONE;
        end else begin
          op = OP_SCAN_NEXT;
          state_next = S_SC_RD;
        end
      end
      S_ME_LINK2: begin
        op = OP_LINK2;
        state_next = S_ME_CHK;
      end
      S_FC_RD: begin
        op = OP_RD_CUR;
        state_next = S_FC_WAIT;
      end
      S_FC_WAIT: begin
        op = OP_FREE_STEP;
        state_next = (stat.rd_tag == TAG_BLK) ? S_FC_RD : S_DONE;
      end
      S_TR_CHK: begin
        if (!stat.cnt_done && stat.cur_valid) begin
          op = OP_RD_CUR;
          state_next = S_TR_WAIT;
        end else begin
          state_next = S_TR_CUT;
        end
      end
      S_TR_WAIT: begin
        op = OP_TR_STEP;
        state_next = S_TR_CHK;
      end
      S_TR_CUT: begin
        op = OP_TR_CUT;
        state_next = stat.cur_valid ? S_FC_RD : S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/fbcm_checker.sv
// Port-level checks for the FAT block chain manager, bound to the top level.
// Depends on fbcm_pkg for codes and widths.
module fbcm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input logic [1:0]     rsp_status,
  input logic           rsp_block_valid,
  input fbcm_pkg::blk_t rsp_block_num
);
  import fbcm_pkg::*;

  // The clearing pass after reset keeps requests out.
  a_reset_clear: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken right after reset");

  // Only one request word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in work");

  // A failed walk or allocation never reports a block.
  a_no_block_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_END || rsp_status == ST_NO_SPACE))
      |-> !rsp_block_valid)
    else $error("block reported with failing status");

  // A held response word stays unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_block_num)
      && $stable(rsp_status)))
    else $error("response word changed while stalled");

endmodule

bind fat_block_chain_manager fbcm_checker u_fbcm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_block_valid (rsp.block_valid),
  .rsp_block_num   (rsp.block_num)
);
